@@ src/pbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, constants and reset values for the blaster controller.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int ADC_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMITED_CAP   = 2'd0,
        CFG_UNLIMITED_CAP = 2'd1,
        CFG_OFFSET_COUNTS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_CHARGING = 2'd1,
        PH_CHARGED  = 2'd2,
        PH_CANCELED = 2'd3
    } t_phase;

    localparam logic [6:0] MAG_MAX         = 7'd99;
    localparam logic [6:0] DARTS_RST       = 7'd10;
    localparam logic [6:0] CAP_RST         = 7'd10;
    localparam logic [7:0] LIMITED_RST     = 8'd50;
    localparam logic [7:0] UNLIMITED_RST   = 8'd100;
    localparam logic [9:0] OFFSET_RST      = 10'd99;
    localparam logic [8:0] PSI_SCALE       = 9'd375;

    typedef struct packed {
        logic [7:0] tank_psi;
        logic [7:0] target_psi;
        logic [7:0] bar_mask;
    } t_psi;

    typedef struct packed {
        logic       fire_pulse;
        logic       vent_pulse;
        logic [1:0] phase;
        logic [6:0] darts_left;
        logic [6:0] magazine_size;
        t_psi       psi;
        logic       limiter_active;
    } t_result;

endpackage

@@ src/pbc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_in_if
// Tick channel: sampled switches, encoder pins and the two ADC samples.
// ----------------------------------------------------------------------------
interface pbc_in_if #(
    parameter int ADC_BITS = pbc_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                trigger_held;
    logic                cancel_level;
    logic                limiter_switch;
    logic                magazine_switch;
    logic                enc_clk;
    logic                enc_dt;
    logic [ADC_BITS-1:0] pressure_sample;
    logic [ADC_BITS-1:0] selector_sample;

    modport source (
        output valid, trigger_held, cancel_level, limiter_switch, magazine_switch,
               enc_clk, enc_dt, pressure_sample, selector_sample,
        input  ready
    );
    modport sink (
        input  valid, trigger_held, cancel_level, limiter_switch, magazine_switch,
               enc_clk, enc_dt, pressure_sample, selector_sample,
        output ready
    );
endinterface

@@ src/pbc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_out_if
// Result channel: firing pulses, phase, dart counts, pressures and bar mask.
// ----------------------------------------------------------------------------
interface pbc_out_if;
    logic       valid;
    logic       ready;
    logic       fire_pulse;
    logic       vent_pulse;
    logic [1:0] phase;
    logic [6:0] darts_left;
    logic [6:0] magazine_size;
    logic [7:0] tank_psi;
    logic [7:0] target_psi;
    logic [7:0] bar_mask;
    logic       limiter_active;

    modport source (
        output valid, fire_pulse, vent_pulse, phase, darts_left, magazine_size,
               tank_psi, target_psi, bar_mask, limiter_active,
        input  ready
    );
    modport sink (
        input  valid, fire_pulse, vent_pulse, phase, darts_left, magazine_size,
               tank_psi, target_psi, bar_mask, limiter_active,
        output ready
    );
endinterface

@@ src/pbc_pressure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pressure
// Tank and target pressure in psi and the eight-segment pressure bar.
// ----------------------------------------------------------------------------
module pbc_pressure #(
    parameter int ADC_BITS = pbc_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0] i_pressure_sample,
    input  logic [ADC_BITS-1:0] i_selector_sample,
    input  logic [7:0]          i_limited_cap,
    input  logic [7:0]          i_unlimited_cap,
    input  logic [9:0]          i_offset_counts,
    input  logic                i_limiter_on,
    output pbc_pkg::t_psi       o_psi
);
    import pbc_pkg::*;

    localparam int AW = (ADC_BITS > 10) ? ADC_BITS : 10;
    localparam int PW = AW + 9;
    localparam int TW = ADC_BITS + 8;

    logic [AW-1:0] w_samp;
    logic [AW-1:0] w_off;
    logic [AW-1:0] w_diff;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_tank_full;
    logic [7:0]    w_tank;
    logic [TW-1:0] w_sel_prod;
    logic [7:0]    w_target;
    logic [12:0]   w_tank_x8;
    logic [12:0]   w_tank_x16;
    logic [7:0]    w_bars;

    assign w_samp      = AW'(i_pressure_sample);
    assign w_off       = AW'(i_offset_counts);
    assign w_diff      = (w_samp > w_off) ? (w_samp - w_off) : '0;
    assign w_prod      = PW'(w_diff) * PW'(PSI_SCALE);
    assign w_tank_full = w_prod >> (ADC_BITS + 1);
    assign w_tank      = (w_tank_full > PW'(255)) ? 8'd255 : w_tank_full[7:0];

    assign w_sel_prod  = TW'(i_selector_sample) * TW'(i_unlimited_cap);

    always_comb begin
        w_target = w_sel_prod[TW-1:ADC_BITS];
        if (i_limiter_on && (w_target > i_limited_cap)) begin
            w_target = i_limited_cap;
        end
        if (w_target > i_unlimited_cap) begin
            w_target = i_unlimited_cap;
        end
    end

    assign w_tank_x8  = {2'b00, w_tank, 3'b000};
    assign w_tank_x16 = {1'b0, w_tank, 4'b0000};

    always_comb begin
        for (int k = 1; k <= 7; k++) begin
            w_bars[k-1] = (w_tank_x8 >= 13'(w_target) * 13'(k));
        end
        w_bars[7] = (w_tank_x16 >= 13'(w_target) * 13'd15);
    end

    assign o_psi.tank_psi   = w_tank;
    assign o_psi.target_psi = w_target;
    assign o_psi.bar_mask   = w_bars;

endmodule

@@ src/pneumatic_blaster_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pneumatic_blaster_controller
// Per-tick controller for a pneumatic blaster: magazine size from a rotary
// encoder, dart count, trigger/cancel firing phase, tank and target pressure
// and the pressure bar.
//
// i_in carries one tick of sampled switches, encoder pins and two ADC
// samples; o_out carries exactly one result transaction per tick, in order.
// Configuration (limiter cap, full-scale cap, transducer offset) is written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must do so only while
// no tick is in flight (not enforced). The tick is registered, then evaluated
// against the current state in one pass into the result register. One tick
// per cycle is sustained while o_out is ready; the input and result registers
// decouple the two sides, so a tick is still taken while a result waits. A
// stalled receiver holds the result and backs up into i_in.ready only once
// both registers are full. Reset restores caps 50/100 psi, offset 99 counts,
// idle phase, ten darts, magazine size ten and the limiter on.
// ----------------------------------------------------------------------------
module pneumatic_blaster_controller #(
    parameter int ADC_BITS = pbc_pkg::ADC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pbc_in_if.sink                           i_in,
    pbc_out_if.source                        o_out
);
    import pbc_pkg::*;

    logic [7:0]          r_limited_cap;
    logic [7:0]          r_unlimited_cap;
    logic [9:0]          r_offset_counts;

    logic                r_in_valid;
    logic                r_trig;
    logic                r_cancel;
    logic                r_lim_sw;
    logic                r_mag_sw;
    logic                r_enc_clk;
    logic                r_enc_dt;
    logic [ADC_BITS-1:0] r_psamp;
    logic [ADC_BITS-1:0] r_ssamp;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [6:0]          r_darts;
    logic [6:0]          n_darts;
    logic [6:0]          r_cap;
    logic [6:0]          n_cap;
    logic                r_limiter;
    logic                n_limiter;
    logic                r_prev_mag;
    logic                r_prev_lim;
    logic                r_prev_clk;

    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                w_advance;
    logic                w_fire;
    logic                w_vent;
    logic [6:0]          w_enc_cap;
    logic [6:0]          w_enc_darts;
    logic [6:0]          w_fire_darts;
    t_psi                w_psi;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limited_cap   <= LIMITED_RST;
            r_unlimited_cap <= UNLIMITED_RST;
            r_offset_counts <= OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LIMITED_CAP:   r_limited_cap   <= i_cfg_data[7:0];
                CFG_UNLIMITED_CAP: r_unlimited_cap <= i_cfg_data[7:0];
                CFG_OFFSET_COUNTS: r_offset_counts <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_trig    <= i_in.trigger_held;
            r_cancel  <= i_in.cancel_level;
            r_lim_sw  <= i_in.limiter_switch;
            r_mag_sw  <= i_in.magazine_switch;
            r_enc_clk <= i_in.enc_clk;
            r_enc_dt  <= i_in.enc_dt;
            r_psamp   <= i_in.pressure_sample;
            r_ssamp   <= i_in.selector_sample;
        end
    end

    pbc_pressure #(
        .ADC_BITS (ADC_BITS)
    ) u_pressure (
        .i_pressure_sample (r_psamp),
        .i_selector_sample (r_ssamp),
        .i_limited_cap     (r_limited_cap),
        .i_unlimited_cap   (r_unlimited_cap),
        .i_offset_counts   (r_offset_counts),
        .i_limiter_on      (r_limiter),
        .o_psi             (w_psi)
    );

    // encoder step on magazine size, dragging the dart count along
    always_comb begin
        w_enc_cap   = r_cap;
        w_enc_darts = r_darts;
        if (r_enc_clk != r_prev_clk) begin
            if (r_enc_dt != r_enc_clk) begin
                if (r_cap < MAG_MAX) begin
                    w_enc_cap = r_cap + 7'd1;
                end
                if ((w_enc_cap != 7'd0) && (r_darts == w_enc_cap - 7'd1)) begin
                    w_enc_darts = r_darts + 7'd1;
                end
            end else begin
                if (r_cap != 7'd0) begin
                    w_enc_cap = r_cap - 7'd1;
                end
                if (r_darts > w_enc_cap) begin
                    w_enc_darts = r_darts - 7'd1;
                end
            end
        end
    end

    // firing machine: next state
    always_comb begin
        if (w_vent) begin
            n_phase = PH_CANCELED;
        end else if (r_trig) begin
            unique case (r_phase)
                PH_IDLE:     n_phase = PH_CHARGING;
                PH_CHARGING: n_phase = PH_CHARGING;
                PH_CHARGED:  n_phase = PH_CHARGED;
                PH_CANCELED: n_phase = PH_CANCELED;
                default:     n_phase = PH_IDLE;
            endcase
        end else begin
            n_phase = PH_IDLE;
        end
    end

    // firing machine: outputs
    always_comb begin
        w_fire = !r_trig && ((r_phase == PH_CHARGING) || (r_phase == PH_CHARGED));
        w_vent = !r_cancel && r_trig && (r_phase != PH_CANCELED);
    end

    always_comb begin
        w_fire_darts = w_enc_darts;
        if (w_fire && (w_enc_darts != 7'd0)) begin
            w_fire_darts = w_enc_darts - 7'd1;
        end
        n_darts = w_fire_darts;
        if (r_mag_sw != r_prev_mag) begin
            n_darts = r_mag_sw ? w_enc_cap : 7'd0;
        end
        n_cap     = w_enc_cap;
        n_limiter = (r_lim_sw != r_prev_lim) ? r_lim_sw : r_limiter;
    end

    always_comb begin
        n_out.fire_pulse     = w_fire;
        n_out.vent_pulse     = w_vent;
        n_out.phase          = n_phase;
        n_out.darts_left     = n_darts;
        n_out.magazine_size  = n_cap;
        n_out.psi            = w_psi;
        n_out.limiter_active = n_limiter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_darts     <= DARTS_RST;
            r_cap       <= CAP_RST;
            r_limiter   <= 1'b1;
            r_prev_mag  <= 1'b0;
            r_prev_lim  <= 1'b0;
            r_prev_clk  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase    <= n_phase;
                r_darts    <= n_darts;
                r_cap      <= n_cap;
                r_limiter  <= n_limiter;
                r_prev_mag <= r_mag_sw;
                r_prev_lim <= r_lim_sw;
                r_prev_clk <= r_enc_clk;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.fire_pulse     = r_out.fire_pulse;
    assign o_out.vent_pulse     = r_out.vent_pulse;
    assign o_out.phase          = r_out.phase;
    assign o_out.darts_left     = r_out.darts_left;
    assign o_out.magazine_size  = r_out.magazine_size;
    assign o_out.tank_psi       = r_out.psi.tank_psi;
    assign o_out.target_psi     = r_out.psi.target_psi;
    assign o_out.bar_mask       = r_out.psi.bar_mask;
    assign o_out.limiter_active = r_out.limiter_active;

endmodule
